@@ design/lvm_pkg.sv @@
package lvm_pkg;

    // magnitude window used while normalising a vector
    localparam int NORM_BITS = 30;
    localparam int NORM_MSB  = 29;

    // square root unit widths
    localparam int RAD_BITS  = 62;
    localparam int ROOT_BITS = 31;

    // saturation bounds for the translation terms
    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] upvec_x;
        logic signed [31:0] upvec_y;
        logic signed [31:0] upvec_z;
    } item_t;

    typedef struct packed {
        logic signed [31:0] right_x;
        logic signed [31:0] right_y;
        logic signed [31:0] right_z;
        logic signed [31:0] right_shift;
        logic signed [31:0] camup_x;
        logic signed [31:0] camup_y;
        logic signed [31:0] camup_z;
        logic signed [31:0] camup_shift;
        logic signed [31:0] back_x;
        logic signed [31:0] back_y;
        logic signed [31:0] back_z;
        logic signed [31:0] back_shift;
    } result_t;

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] y;
        if (x > SAT_HI)
        begin
            y = SAT_HI[31:0];
        end
        else if (x < SAT_LO)
        begin
            y = SAT_LO[31:0];
        end
        else
        begin
            y = x[31:0];
        end
        return y;
    endfunction

endpackage

@@ design/lvm_isqrt.sv @@
module lvm_isqrt
    import lvm_pkg::*;
#(
    parameter int PW = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [RAD_BITS-1:0]  in_rad,
    input  logic [PW-1:0]        in_pay,
    output logic                 out_valid,
    output logic [ROOT_BITS-1:0] out_root,
    output logic [PW-1:0]        out_pay
);

    localparam int TW = RAD_BITS + 1;

    logic                 vld_reg  [ROOT_BITS];
    logic [RAD_BITS-1:0]  rem_reg  [ROOT_BITS];
    logic [ROOT_BITS-1:0] root_reg [ROOT_BITS];
    logic [PW-1:0]        pay_reg  [ROOT_BITS];

    // one root bit per stage, most significant first
    for (genvar k = 0; k < ROOT_BITS; k++)
    begin : g_stage
        localparam int J = ROOT_BITS - 1 - k;

        logic                 v_cur;
        logic [RAD_BITS-1:0]  rem_cur;
        logic [RAD_BITS-1:0]  rem_next;
        logic [ROOT_BITS-1:0] root_cur;
        logic [ROOT_BITS-1:0] root_next;
        logic [PW-1:0]        pay_cur;
        logic [TW-1:0]        trial;

        if (k == 0)
        begin : g_first
            assign v_cur    = in_valid;
            assign rem_cur  = in_rad;
            assign root_cur = '0;
            assign pay_cur  = in_pay;
        end
        else
        begin : g_rest
            assign v_cur    = vld_reg[k-1];
            assign rem_cur  = rem_reg[k-1];
            assign root_cur = root_reg[k-1];
            assign pay_cur  = pay_reg[k-1];
        end

        // (root + 2^j)^2 - root^2
        assign trial = (TW'(root_cur) << (J + 1)) | (TW'(1) << (2 * J));

        always_comb
        begin
            if (TW'(rem_cur) >= trial)
            begin
                rem_next  = rem_cur - trial[RAD_BITS-1:0];
                root_next = root_cur | (ROOT_BITS'(1) << J);
            end
            else
            begin
                rem_next  = rem_cur;
                root_next = root_cur;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= v_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            root_reg[k] <= root_next;
            pay_reg[k]  <= pay_cur;
        end
    end

    assign out_valid = vld_reg[ROOT_BITS-1];
    assign out_root  = root_reg[ROOT_BITS-1];
    assign out_pay   = pay_reg[ROOT_BITS-1];

endmodule

@@ design/lvm_divide.sv @@
module lvm_divide
    import lvm_pkg::*;
#(
    parameter int FB = 16,
    parameter int PW = 8
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [2:0][NORM_BITS+FB:0]        in_num,
    input  logic [ROOT_BITS-1:0]              in_den,
    input  logic [PW-1:0]                     in_pay,
    output logic                              out_valid,
    output logic [2:0][FB:0]                  out_quo,
    output logic [PW-1:0]                     out_pay
);

    localparam int NW = NORM_BITS + FB + 1;
    localparam int QB = FB + 1;

    logic                 vld_reg [QB];
    logic [2:0][NW-1:0]   rem_reg [QB];
    logic [2:0][QB-1:0]   quo_reg [QB];
    logic [ROOT_BITS-1:0] den_reg [QB];
    logic [PW-1:0]        pay_reg [QB];

    // restoring division, one quotient bit per stage, three lanes share the divisor
    for (genvar k = 0; k < QB; k++)
    begin : g_stage
        localparam int J = QB - 1 - k;

        logic                 v_cur;
        logic [2:0][NW-1:0]   rem_cur;
        logic [2:0][NW-1:0]   rem_next;
        logic [2:0][QB-1:0]   quo_cur;
        logic [2:0][QB-1:0]   quo_next;
        logic [ROOT_BITS-1:0] den_cur;
        logic [PW-1:0]        pay_cur;
        logic [NW-1:0]        trial;

        if (k == 0)
        begin : g_first
            assign v_cur   = in_valid;
            assign rem_cur = in_num;
            assign quo_cur = '0;
            assign den_cur = in_den;
            assign pay_cur = in_pay;
        end
        else
        begin : g_rest
            assign v_cur   = vld_reg[k-1];
            assign rem_cur = rem_reg[k-1];
            assign quo_cur = quo_reg[k-1];
            assign den_cur = den_reg[k-1];
            assign pay_cur = pay_reg[k-1];
        end

        assign trial = NW'(den_cur) << J;

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (rem_cur[i] >= trial)
                begin
                    rem_next[i] = rem_cur[i] - trial;
                    quo_next[i] = quo_cur[i] | (QB'(1) << J);
                end
                else
                begin
                    rem_next[i] = rem_cur[i];
                    quo_next[i] = quo_cur[i];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= v_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            quo_reg[k] <= quo_next;
            den_reg[k] <= den_cur;
            pay_reg[k] <= pay_cur;
        end
    end

    assign out_valid = vld_reg[QB-1];
    assign out_quo   = quo_reg[QB-1];
    assign out_pay   = pay_reg[QB-1];

endmodule

@@ design/lvm_unitize.sv @@
module lvm_unitize
    import lvm_pkg::*;
#(
    parameter int W  = 33,
    parameter int FB = 16,
    parameter int PW = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [2:0][W-1:0]   in_vec,
    input  logic [PW-1:0]       in_pay,
    output logic                out_valid,
    output logic [2:0][FB+1:0]  out_unit,
    output logic [PW-1:0]       out_pay
);

    localparam int PB  = $clog2(W);
    localparam int NW  = NORM_BITS + FB + 1;
    localparam int SQ  = 2 * NORM_BITS;
    localparam int UW  = FB + 2;
    localparam int SPW = PW + 4 + 3 * NORM_BITS;
    localparam int DPW = PW + 4;

    // stage 1: sign and magnitude
    logic                 v1_reg;
    logic [2:0][W-1:0]    mag1_reg;
    logic [2:0][W-1:0]    mag1_next;
    logic [2:0]           neg1_reg;
    logic [2:0]           neg1_next;
    logic [PW-1:0]        pay1_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg1_next[i] = in_vec[i][W-1];
            mag1_next[i] = neg1_next[i] ? (~in_vec[i] + W'(1)) : in_vec[i];
        end
    end

    // stage 2: leading one of the largest magnitude and the shift to the window
    logic                 v2_reg;
    logic [2:0][W-1:0]    mag2_reg;
    logic [2:0]           neg2_reg;
    logic                 zero2_reg;
    logic                 zero2_next;
    logic                 rsh2_reg;
    logic                 rsh2_next;
    logic [PB-1:0]        amt2_reg;
    logic [PB-1:0]        amt2_next;
    logic [PW-1:0]        pay2_reg;
    logic [W-1:0]         orv;
    logic [PB-1:0]        pos;

    always_comb
    begin
        orv = mag1_reg[0] | mag1_reg[1] | mag1_reg[2];
        pos = '0;
        for (int i = 0; i < W; i++)
        begin
            if (orv[i])
            begin
                pos = PB'(i);
            end
        end
        zero2_next = (orv == '0);
        rsh2_next  = (pos > PB'(NORM_MSB));
        amt2_next  = rsh2_next ? (pos - PB'(NORM_MSB)) : (PB'(NORM_MSB) - pos);
    end

    // stage 3: normalised magnitudes
    logic                       v3_reg;
    logic [2:0][NORM_BITS-1:0]  m3_reg;
    logic [2:0][NORM_BITS-1:0]  m3_next;
    logic [2:0]                 neg3_reg;
    logic                       zero3_reg;
    logic [PW-1:0]              pay3_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (rsh2_reg)
            begin
                m3_next[i] = NORM_BITS'(mag2_reg[i] >> amt2_reg);
            end
            else
            begin
                m3_next[i] = mag2_reg[i][NORM_BITS-1:0] << amt2_reg;
            end
        end
    end

    // stage 4: squares
    logic                       v4_reg;
    logic [2:0][SQ-1:0]         sq4_reg;
    logic [2:0][SQ-1:0]         sq4_next;
    logic [2:0][NORM_BITS-1:0]  m4_reg;
    logic [2:0]                 neg4_reg;
    logic                       zero4_reg;
    logic [PW-1:0]              pay4_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq4_next[i] = SQ'(m3_reg[i]) * SQ'(m3_reg[i]);
        end
    end

    // stage 5: sum of squares
    logic                       v5_reg;
    logic [RAD_BITS-1:0]        rad5_reg;
    logic [RAD_BITS-1:0]        rad5_next;
    logic [2:0][NORM_BITS-1:0]  m5_reg;
    logic [2:0]                 neg5_reg;
    logic                       zero5_reg;
    logic [PW-1:0]              pay5_reg;

    assign rad5_next = RAD_BITS'(sq4_reg[0]) + RAD_BITS'(sq4_reg[1]) + RAD_BITS'(sq4_reg[2]);

    // length by integer square root
    logic                       sv;
    logic [ROOT_BITS-1:0]       root;
    logic [SPW-1:0]             spay;
    logic [PW-1:0]              sp_pay;
    logic [2:0]                 sp_neg;
    logic                       sp_zero;
    logic [2:0][NORM_BITS-1:0]  sp_m;

    lvm_isqrt #(
        .PW (SPW)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .in_rad    (rad5_reg),
        .in_pay    ({pay5_reg, neg5_reg, zero5_reg, m5_reg}),
        .out_valid (sv),
        .out_root  (root),
        .out_pay   (spay)
    );

    assign {sp_pay, sp_neg, sp_zero, sp_m} = spay;

    // stage 6: rounded dividends
    logic                       v6_reg;
    logic [2:0][NW-1:0]         num6_reg;
    logic [2:0][NW-1:0]         num6_next;
    logic [ROOT_BITS-1:0]       den6_reg;
    logic [DPW-1:0]             pay6_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num6_next[i] = (NW'(sp_m[i]) << FB) + NW'(root >> 1);
        end
    end

    // component over length
    logic                       dv;
    logic [2:0][FB:0]           quo;
    logic [DPW-1:0]             dpay;
    logic [PW-1:0]              dp_pay;
    logic [2:0]                 dp_neg;
    logic                       dp_zero;

    lvm_divide #(
        .FB (FB),
        .PW (DPW)
    ) u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v6_reg),
        .in_num    (num6_reg),
        .in_den    (den6_reg),
        .in_pay    (pay6_reg),
        .out_valid (dv),
        .out_quo   (quo),
        .out_pay   (dpay)
    );

    assign {dp_pay, dp_neg, dp_zero} = dpay;

    // stage 7: restore signs, zero vector stays zero
    logic                       v7_reg;
    logic [2:0][UW-1:0]         unit7_reg;
    logic [2:0][UW-1:0]         unit7_next;
    logic [PW-1:0]              pay7_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dp_zero)
            begin
                unit7_next[i] = '0;
            end
            else if (dp_neg[i])
            begin
                unit7_next[i] = UW'(0) - UW'(quo[i]);
            end
            else
            begin
                unit7_next[i] = UW'(quo[i]);
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= sv;
            v7_reg <= dv;
        end
    end

    // data path registers
    always_ff @(posedge clk)
    begin
        mag1_reg  <= mag1_next;
        neg1_reg  <= neg1_next;
        pay1_reg  <= in_pay;

        mag2_reg  <= mag1_reg;
        neg2_reg  <= neg1_reg;
        zero2_reg <= zero2_next;
        rsh2_reg  <= rsh2_next;
        amt2_reg  <= amt2_next;
        pay2_reg  <= pay1_reg;

        m3_reg    <= m3_next;
        neg3_reg  <= neg2_reg;
        zero3_reg <= zero2_reg;
        pay3_reg  <= pay2_reg;

        sq4_reg   <= sq4_next;
        m4_reg    <= m3_reg;
        neg4_reg  <= neg3_reg;
        zero4_reg <= zero3_reg;
        pay4_reg  <= pay3_reg;

        rad5_reg  <= rad5_next;
        m5_reg    <= m4_reg;
        neg5_reg  <= neg4_reg;
        zero5_reg <= zero4_reg;
        pay5_reg  <= pay4_reg;

        num6_reg  <= num6_next;
        den6_reg  <= root;
        pay6_reg  <= {sp_pay, sp_neg, sp_zero};

        unit7_reg <= unit7_next;
        pay7_reg  <= dp_pay;
    end

    assign out_valid = v7_reg;
    assign out_unit  = unit7_reg;
    assign out_pay   = pay7_reg;

endmodule

@@ design/lookat_view_matrix_top.sv @@
// look-at view matrix, fully pipelined, one camera transaction per clock
// throughput: one transaction per cycle, set by the two normalise pipelines
// (31-stage square root and FRAC_BITS+1-stage divider each); busy stays low
// reset: rst_n clears all valid bits at once, no result is pending after reset
// the receiver cannot stall: each result shows for one cycle with done high
module lookat_view_matrix_top
    import lvm_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  item_t   item,
    output logic    busy,
    output logic    done,
    output result_t result
);

    localparam int FB   = FRAC_BITS;
    localparam int UW   = FB + 2;
    localparam int DW   = 33;
    localparam int XW   = UW + 32;
    localparam int CW   = XW + 1;
    localparam int UUW  = 2 * UW;
    localparam int UXW  = UW + 1;
    localparam int DTW  = UW + 32;
    localparam int UEW  = UXW + 32;
    localparam int P1W  = 6 * 32;
    localparam int P2W  = 3 * 32 + 3 * UW;
    localparam logic signed [63:0] HALF = 64'sd1 <<< (FB - 1);

    assign busy = 1'b0;

    // input register
    logic       in_v_reg;
    item_t      in_reg;

    // stage d: direction to target
    logic               d_v_reg;
    logic [2:0][DW-1:0] d_reg;
    logic [2:0][DW-1:0] d_next;
    logic [2:0][31:0]   eye_d_reg;
    logic [2:0][31:0]   up_d_reg;

    assign d_next[0] = DW'(in_reg.target_x) - DW'(in_reg.eye_x);
    assign d_next[1] = DW'(in_reg.target_y) - DW'(in_reg.eye_y);
    assign d_next[2] = DW'(in_reg.target_z) - DW'(in_reg.eye_z);

    // forward vector
    logic               f_v;
    logic [2:0][UW-1:0] f1;
    logic [P1W-1:0]     pay1;
    logic [2:0][31:0]   eye1;
    logic [2:0][31:0]   up1;

    lvm_unitize #(
        .W  (DW),
        .FB (FB),
        .PW (P1W)
    ) u_unit_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_v_reg),
        .in_vec    (d_reg),
        .in_pay    ({eye_d_reg, up_d_reg}),
        .out_valid (f_v),
        .out_unit  (f1),
        .out_pay   (pay1)
    );

    assign {eye1, up1} = pay1;

    // stage x1: cross product terms of forward and up hint
    logic               x1_v_reg;
    logic [5:0][XW-1:0] xp_reg;
    logic [5:0][XW-1:0] xp_next;
    logic [2:0][31:0]   eye_x1_reg;
    logic [2:0][UW-1:0] f_x1_reg;

    assign xp_next[0] = XW'($signed(f1[1])) * XW'($signed(up1[2]));
    assign xp_next[1] = XW'($signed(f1[2])) * XW'($signed(up1[1]));
    assign xp_next[2] = XW'($signed(f1[2])) * XW'($signed(up1[0]));
    assign xp_next[3] = XW'($signed(f1[0])) * XW'($signed(up1[2]));
    assign xp_next[4] = XW'($signed(f1[0])) * XW'($signed(up1[1]));
    assign xp_next[5] = XW'($signed(f1[1])) * XW'($signed(up1[0]));

    // stage x2: exact cross product
    logic               x2_v_reg;
    logic [2:0][CW-1:0] c_reg;
    logic [2:0][CW-1:0] c_next;
    logic [2:0][31:0]   eye_x2_reg;
    logic [2:0][UW-1:0] f_x2_reg;

    assign c_next[0] = CW'($signed(xp_reg[0])) - CW'($signed(xp_reg[1]));
    assign c_next[1] = CW'($signed(xp_reg[2])) - CW'($signed(xp_reg[3]));
    assign c_next[2] = CW'($signed(xp_reg[4])) - CW'($signed(xp_reg[5]));

    // right vector
    logic               r_v;
    logic [2:0][UW-1:0] r2;
    logic [P2W-1:0]     pay2;
    logic [2:0][31:0]   eye2;
    logic [2:0][UW-1:0] f2;

    lvm_unitize #(
        .W  (CW),
        .FB (FB),
        .PW (P2W)
    ) u_unit_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (x2_v_reg),
        .in_vec    (c_reg),
        .in_pay    ({eye_x2_reg, f_x2_reg}),
        .out_valid (r_v),
        .out_unit  (r2),
        .out_pay   (pay2)
    );

    assign {eye2, f2} = pay2;

    // stage y1: products for camera up and the right and forward dot terms
    logic                y1_v_reg;
    logic [5:0][UUW-1:0] up_reg;
    logic [5:0][UUW-1:0] up_next;
    logic [2:0][DTW-1:0] rd_reg;
    logic [2:0][DTW-1:0] rd_next;
    logic [2:0][DTW-1:0] fd_reg;
    logic [2:0][DTW-1:0] fd_next;
    logic [2:0][31:0]    eye_y1_reg;
    logic [2:0][UW-1:0]  r_y1_reg;
    logic [2:0][UW-1:0]  f_y1_reg;

    assign up_next[0] = UUW'($signed(r2[1])) * UUW'($signed(f2[2]));
    assign up_next[1] = UUW'($signed(r2[2])) * UUW'($signed(f2[1]));
    assign up_next[2] = UUW'($signed(r2[2])) * UUW'($signed(f2[0]));
    assign up_next[3] = UUW'($signed(r2[0])) * UUW'($signed(f2[2]));
    assign up_next[4] = UUW'($signed(r2[0])) * UUW'($signed(f2[1]));
    assign up_next[5] = UUW'($signed(r2[1])) * UUW'($signed(f2[0]));

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rd_next[i] = DTW'($signed(r2[i])) * DTW'($signed(eye2[i]));
            fd_next[i] = DTW'($signed(f2[i])) * DTW'($signed(eye2[i]));
        end
    end

    // stage y2: rounded camera up, right and back translation terms
    logic                y2_v_reg;
    logic [2:0][UXW-1:0] u_reg;
    logic [2:0][UXW-1:0] u_next;
    logic [31:0]         rsh_reg;
    logic [31:0]         rsh_next;
    logic [31:0]         bsh_reg;
    logic [31:0]         bsh_next;
    logic [2:0][31:0]    eye_y2_reg;
    logic [2:0][UW-1:0]  r_y2_reg;
    logic [2:0][UW-1:0]  f_y2_reg;
    logic signed [63:0]  ud [3];
    logic signed [63:0]  rsum;
    logic signed [63:0]  fsum;

    always_comb
    begin
        ud[0] = 64'($signed(up_reg[0])) - 64'($signed(up_reg[1]));
        ud[1] = 64'($signed(up_reg[2])) - 64'($signed(up_reg[3]));
        ud[2] = 64'($signed(up_reg[4])) - 64'($signed(up_reg[5]));
        for (int i = 0; i < 3; i++)
        begin
            ud[i]     = (ud[i] + HALF) >>> FB;
            u_next[i] = ud[i][UXW-1:0];
        end
        rsum = 64'($signed(rd_reg[0])) + 64'($signed(rd_reg[1]))
             + 64'($signed(rd_reg[2]));
        fsum = 64'($signed(fd_reg[0])) + 64'($signed(fd_reg[1]))
             + 64'($signed(fd_reg[2]));
        rsum = (rsum + HALF) >>> FB;
        fsum = (fsum + HALF) >>> FB;
        rsh_next = sat32(-rsum);
        bsh_next = sat32(fsum);
    end

    // stage y3: camera up dot eye products
    logic                y3_v_reg;
    logic [2:0][UEW-1:0] ue_reg;
    logic [2:0][UEW-1:0] ue_next;
    logic [2:0][UXW-1:0] u_y3_reg;
    logic [2:0][UW-1:0]  r_y3_reg;
    logic [2:0][UW-1:0]  f_y3_reg;
    logic [31:0]         rsh_y3_reg;
    logic [31:0]         bsh_y3_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ue_next[i] = UEW'($signed(u_reg[i])) * UEW'($signed(eye_y2_reg[i]));
        end
    end

    // stage y4: result register
    logic               done_reg;
    result_t            result_reg;
    result_t            result_next;
    logic signed [63:0] usum;

    always_comb
    begin
        usum = 64'($signed(ue_reg[0])) + 64'($signed(ue_reg[1]))
             + 64'($signed(ue_reg[2]));
        usum = (usum + HALF) >>> FB;
        result_next.right_x     = 32'($signed(r_y3_reg[0]));
        result_next.right_y     = 32'($signed(r_y3_reg[1]));
        result_next.right_z     = 32'($signed(r_y3_reg[2]));
        result_next.right_shift = rsh_y3_reg;
        result_next.camup_x     = 32'($signed(u_y3_reg[0]));
        result_next.camup_y     = 32'($signed(u_y3_reg[1]));
        result_next.camup_z     = 32'($signed(u_y3_reg[2]));
        result_next.camup_shift = sat32(-usum);
        result_next.back_x      = 32'sd0 - 32'($signed(f_y3_reg[0]));
        result_next.back_y      = 32'sd0 - 32'($signed(f_y3_reg[1]));
        result_next.back_z      = 32'sd0 - 32'($signed(f_y3_reg[2]));
        result_next.back_shift  = bsh_y3_reg;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
            d_v_reg  <= 1'b0;
            x1_v_reg <= 1'b0;
            x2_v_reg <= 1'b0;
            y1_v_reg <= 1'b0;
            y2_v_reg <= 1'b0;
            y3_v_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            in_v_reg <= start & ~busy;
            d_v_reg  <= in_v_reg;
            x1_v_reg <= f_v;
            x2_v_reg <= x1_v_reg;
            y1_v_reg <= r_v;
            y2_v_reg <= y1_v_reg;
            y3_v_reg <= y2_v_reg;
            done_reg <= y3_v_reg;
        end
    end

    // data path registers
    always_ff @(posedge clk)
    begin
        in_reg     <= item;

        d_reg      <= d_next;
        eye_d_reg  <= {in_reg.eye_z, in_reg.eye_y, in_reg.eye_x};
        up_d_reg   <= {in_reg.upvec_z, in_reg.upvec_y, in_reg.upvec_x};

        xp_reg     <= xp_next;
        eye_x1_reg <= eye1;
        f_x1_reg   <= f1;

        c_reg      <= c_next;
        eye_x2_reg <= eye_x1_reg;
        f_x2_reg   <= f_x1_reg;

        up_reg     <= up_next;
        rd_reg     <= rd_next;
        fd_reg     <= fd_next;
        eye_y1_reg <= eye2;
        r_y1_reg   <= r2;
        f_y1_reg   <= f2;

        u_reg      <= u_next;
        rsh_reg    <= rsh_next;
        bsh_reg    <= bsh_next;
        eye_y2_reg <= eye_y1_reg;
        r_y2_reg   <= r_y1_reg;
        f_y2_reg   <= f_y1_reg;

        ue_reg     <= ue_next;
        u_y3_reg   <= u_reg;
        r_y3_reg   <= r_y2_reg;
        f_y3_reg   <= f_y2_reg;
        rsh_y3_reg <= rsh_reg;
        bsh_y3_reg <= bsh_reg;

        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
